// File: rtl/typed_stack_pick_roll_macros.svh
// Assertion macros for the typed stack block.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef TYPED_STACK_PICK_ROLL_MACROS_SVH
`define TYPED_STACK_PICK_ROLL_MACROS_SVH

// checked only outside reset
`define TSP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define TSP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/tsp_pkg.sv
// Types and codes shared by the typed stack block.
// No dependencies; imported by every module of the block but tsp_ram.
package tsp_pkg;

   localparam int unsigned TAG_W     = 2;
   localparam int unsigned PAYLOAD_W = 64;
   localparam int unsigned ENTRY_W   = TAG_W + PAYLOAD_W;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned FILL_W    = 9;
   localparam int unsigned CNT_MAX_W = 17;   // wide enough for the largest stack depth
   localparam int unsigned Q_LVL_W   = 2;    // command queue holds two entries

   localparam logic [1:0] ACT_PUSH = 2'd0;
   localparam logic [1:0] ACT_POP  = 2'd1;
   localparam logic [1:0] ACT_PICK = 2'd2;
   localparam logic [1:0] ACT_ROLL = 2'd3;

   localparam logic [TAG_W-1:0] TAG_INT = 2'd0;

   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNDER  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVER   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTINT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd4;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_POP,
      OP_PICK,
      OP_ROLL
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_POP,
      BK_IDX,
      BK_SRC,
      BK_SHIFT,
      BK_LAST
   } back_state_type;

   typedef struct packed {
      logic [1:0]           action;
      logic [TAG_W-1:0]     value_type;
      logic [PAYLOAD_W-1:0] value_payload;
   } req_type;

   typedef struct packed {
      logic [TAG_W-1:0]     out_type;
      logic [PAYLOAD_W-1:0] out_payload;
      logic [STATUS_W-1:0]  status;
      logic [FILL_W-1:0]    fill;
   } rsp_type;

   typedef struct packed {
      op_type             op;
      logic [ENTRY_W-1:0] entry;   // {tag, payload}, used by push only
   } cmd_type;

   typedef struct packed {
      logic                 busy;
      logic [CNT_MAX_W-1:0] count;
   } back_stat_type;

endpackage

// File: rtl/tsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsp_ram #(
   parameter int unsigned WIDTH = 66,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tsp_front.sv
// Front end: accepts request transactions, decodes the action and queues commands.
// Depends on tsp_pkg.
module tsp_front
   import tsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type            q_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [Q_LVL_W-1:0] level_ff, level_in;
   cmd_type            dec;
   logic               push_q, pop_q;

   always_comb begin
      unique case (req.action)
         ACT_PUSH: dec.op = OP_PUSH;
         ACT_POP:  dec.op = OP_POP;
         ACT_PICK: dec.op = OP_PICK;
         ACT_ROLL: dec.op = OP_ROLL;
         default:  dec.op = OP_PUSH;
      endcase
      dec.entry = {req.value_type, req.value_payload};
   end

   assign req_stall = (level_ff == Q_LVL_W'(2));
   assign push_q    = req_valid && !req_stall;
   assign pop_q     = cmd_pop && (level_ff != '0);
   assign cmd_valid = (level_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_q ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_q ? ~rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff + Q_LVL_W'(push_q) - Q_LVL_W'(pop_q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_q) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// File: rtl/tsp_back.sv
// Back end: stack sequencer over the entry RAM, plus the response register.
// Depends on tsp_pkg and tsp_ram.
module tsp_back
   import tsp_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_valid,
   input  cmd_type       cmd,
   output logic          cmd_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp,
   output back_stat_type stat
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

   back_state_type     state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic               roll_ff, roll_in;
   logic [ENTRY_W-1:0] hold_ff, hold_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;

   logic               slot_free, emit;
   logic [ENTRY_W-1:0] emit_entry;
   logic [STATUS_W-1:0] emit_status;
   logic [CW-1:0]      emit_fill;

   logic [CW-1:0]        m;
   logic [CW-1:0]        ptr_w, nxt1, nxt2, src;
   logic [TAG_W-1:0]     rd_tag;
   logic [PAYLOAD_W-1:0] rd_pay;

   tsp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign m         = count_ff - CW'(1);
   assign ptr_w     = CW'(ptr_ff);
   assign nxt1      = ptr_w + CW'(1);
   assign nxt2      = ptr_w + CW'(2);
   assign rd_tag    = rd_data[ENTRY_W-1:PAYLOAD_W];
   assign rd_pay    = rd_data[PAYLOAD_W-1:0];
   assign src       = m - CW'(1) - rd_pay[CW-1:0];
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      roll_in     = roll_ff;
      hold_in     = hold_ff;
      cmd_pop     = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = rd_data;
      rd_en       = 1'b0;
      rd_addr     = '0;
      emit        = 1'b0;
      emit_entry  = '0;
      emit_status = ST_OK;
      emit_fill   = count_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && slot_free) begin
               cmd_pop = 1'b1;
               if (cmd.op == OP_PUSH) begin
                  emit = 1'b1;
                  if (count_ff == CW'(STACK_DEPTH)) begin
                     emit_status = ST_OVER;
                  end else begin
                     wr_en     = 1'b1;
                     wr_addr   = AW'(count_ff);
                     wr_data   = cmd.entry;
                     count_in  = count_ff + CW'(1);
                     emit_fill = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  emit        = 1'b1;
                  emit_status = ST_UNDER;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(m);
                  roll_in  = (cmd.op == OP_ROLL);
                  state_in = (cmd.op == OP_POP) ? BK_POP : BK_IDX;
               end
            end
         end
         BK_POP: begin
            emit       = 1'b1;
            emit_entry = rd_data;
            emit_fill  = m;
            count_in   = m;
            state_in   = BK_IDLE;
         end
         BK_IDX: begin
            // top entry is the index: must be an int below the remaining depth
            if (rd_tag != TAG_INT) begin
               emit        = 1'b1;
               emit_status = ST_NOTINT;
               state_in    = BK_IDLE;
            end else if (rd_pay >= PAYLOAD_W'(m)) begin
               emit        = 1'b1;
               emit_status = ST_RANGE;
               state_in    = BK_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(src);
               ptr_in   = AW'(src);
               state_in = BK_SRC;
            end
         end
         BK_SRC: begin
            if (!roll_ff) begin
               // pick: copy overwrites the index slot
               wr_en      = 1'b1;
               wr_addr    = AW'(m);
               emit       = 1'b1;
               emit_entry = rd_data;
               state_in   = BK_IDLE;
            end else if (nxt1 < m) begin
               hold_in  = rd_data;
               rd_en    = 1'b1;
               rd_addr  = AW'(nxt1);
               state_in = BK_SHIFT;
            end else begin
               // element already just below the index: lands in place
               wr_en      = 1'b1;
               wr_addr    = AW'(m - CW'(1));
               emit       = 1'b1;
               emit_entry = rd_data;
               emit_fill  = m;
               count_in   = m;
               state_in   = BK_IDLE;
            end
         end
         BK_SHIFT: begin
            // one entry moved down per cycle, next read overlapped
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            ptr_in  = AW'(nxt1);
            if (nxt2 < m) begin
               rd_en   = 1'b1;
               rd_addr = AW'(nxt2);
            end else begin
               state_in = BK_LAST;
            end
         end
         BK_LAST: begin
            wr_en      = 1'b1;
            wr_addr    = AW'(m - CW'(1));
            wr_data    = hold_ff;
            emit       = 1'b1;
            emit_entry = hold_ff;
            emit_fill  = m;
            count_in   = m;
            state_in   = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      if (emit) begin
         rsp_in.out_type    = emit_entry[ENTRY_W-1:PAYLOAD_W];
         rsp_in.out_payload = emit_entry[PAYLOAD_W-1:0];
         rsp_in.status      = emit_status;
         rsp_in.fill        = FILL_W'(emit_fill);
      end else begin
         rsp_in = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      roll_ff <= roll_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;
   assign stat.busy  = (state_ff != BK_IDLE);
   assign stat.count = CNT_MAX_W'(count_ff);

endmodule

// File: rtl/typed_stack_pick_roll.sv
// Typed data stack with push, pop, pick and roll: top level.
// Depends on tsp_pkg, tsp_front, tsp_back (with tsp_ram) and the macros header.
//
// Usage
//  - req_* channel: one transaction per action (push, pop, pick, roll) with the
//    tag and payload to push. Accepted when req_valid is high and req_stall low.
//  - rsp_* channel: exactly one transaction per request, in request order,
//    carrying the returned value, a status code and the fill after the action.
//  - The front end decodes the action into a two-entry command queue; the back
//    end owns the stack count and the entry RAM (one write, one registered read).
//  - Back-end states per action: push or any early error IDLE only, pop POP,
//    pick IDX then SRC, index type or range error IDX, roll at index 0 IDX
//    then SRC, else IDX, SRC, one SHIFT per entry shifted down, and LAST to
//    drop the saved element on top. Queue entries and responses are registered.
//    The next action starts the cycle after the last: one push/cycle unless rsp stalls.
//  - A stalled response is held in the output register; the back end then
//    waits before starting its next command, while the queue still takes
//    up to two further requests before req_stall rises.
//  - Reset empties the stack and the queue and drops any pending response;
//    the entry RAM is not cleared, as only written entries are ever read.
`include "typed_stack_pick_roll_macros.svh"

module typed_stack_pick_roll
   import tsp_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   logic          cmd_valid;
   logic          cmd_pop;
   cmd_type       cmd;
   back_stat_type back_stat;
   logic          rsp_err;
   logic          rsp_no_data;
   logic          all_clear;

   // decode and queue
   tsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // stack sequencer, entry RAM and response register
   tsp_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .stat      (back_stat)
   );

   assign rsp_err     = rsp_valid && (rsp.status != ST_OK);
   assign rsp_no_data = (rsp.out_type == '0) && (rsp.out_payload == '0);
   assign all_clear   = !rsp_valid && !cmd_valid && (back_stat.count == '0);

   // stack count never passes the configured depth
   `TSP_ASSERT(a_count_bound, back_stat.count <= CNT_MAX_W'(STACK_DEPTH), "stack count over depth")

   // every error response carries a zero value
   `TSP_ASSERT(a_err_zero, rsp_err |-> rsp_no_data, "error response with data")

   // a command is only taken by an idle back end
   `TSP_ASSERT(a_pop_idle, cmd_pop |-> (!back_stat.busy && cmd_valid), "command taken while busy")

   // reset leaves no response, no queued command and an empty stack
   `TSP_ASSERT_ALWAYS(a_reset_clear, reset |=> all_clear, "state not cleared by reset")

endmodule

// File: sim/tb_typed_stack_pick_roll.sv
// Testbench for typed_stack_pick_roll: directed table, then random traffic and a full-stack sequence.
// Holds its own stack predictor and checks every response field by field.
// Depends on tsp_pkg and the typed_stack_pick_roll RTL only.
`timescale 1ns / 100ps

module tb_typed_stack_pick_roll;
   import tsp_pkg::*;

   localparam int          STACK_DEPTH    = 256;
   localparam time         CLK_PERIOD     = 20;
   localparam int          WATCHDOG_LIMIT = 4000;  // deepest roll plus the long hold, many times
   localparam int          LONG_HOLD      = 80;    // receiver hold-off, long enough to back up
   localparam int          SETTLE_CYCLES  = 300;   // covers a full-depth roll
   localparam logic [1:0]  TAG_FLOAT      = 2'd1;
   localparam logic [1:0]  TAG_BOOL       = 2'd2;
   localparam logic [1:0]  TAG_PTR        = 2'd3;
   localparam logic [63:0] ALL_ONES       = '1;
   localparam logic [63:0] SIGN_ONLY      = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POSITIVE  = 64'h7FFF_FFFF_FFFF_FFFF;

   // one line of the directed table; want is only used where typed is set
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } probe_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   // shadow copy of the stack: {tag, payload} per entry
   logic [65:0] shadow_ent [STACK_DEPTH];
   int          shadow_fill = 0;
   int          peak_fill   = 0;

   rsp_type rsp_due [$];          // responses still owed by the block, oldest first
   int      mismatches  = 0;
   int      act_seen    [4];
   int      status_seen [8];
   bit      calm        = 1'b0;   // set for the final stretch: no idling on either side
   int      hold_asked  = 0;      // bumped by the sender to request a long receiver hold
   int      hold_taken  = 0;
   int      hold_left   = 0;
   int      idle_cycles = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   typed_stack_pick_roll #(
      .STACK_DEPTH(STACK_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req      (req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp)
   );

   // ------------------------------------------------------------------
   // Predictor: applies one action to the shadow stack, returns the
   // response the block owes for it.
   // ------------------------------------------------------------------
   function automatic rsp_type apply_action(req_type item);
      rsp_type     r;
      logic [63:0] idx;
      logic [65:0] moved;
      int          m;
      int          src;
      r = '0;
      case (item.action)
         ACT_PUSH: begin
            if (shadow_fill >= STACK_DEPTH) begin
               r.status = ST_OVER;
            end else begin
               shadow_ent[shadow_fill] = {item.value_type, item.value_payload};
               shadow_fill++;
            end
         end
         default: begin
            if (shadow_fill == 0) begin
               r.status = ST_UNDER;
            end else if (item.action == ACT_POP) begin
               shadow_fill--;
               {r.out_type, r.out_payload} = shadow_ent[shadow_fill];
            end else if (shadow_ent[shadow_fill - 1][65:64] != TAG_INT) begin
               r.status = ST_NOTINT;
            end else begin
               idx = shadow_ent[shadow_fill - 1][63:0];
               m   = shadow_fill - 1;
               // unsigned compare also rejects negative indices
               if (idx >= 64'(m)) begin
                  r.status = ST_RANGE;
               end else begin
                  src   = m - 1 - int'(idx[31:0]);
                  moved = shadow_ent[src];
                  {r.out_type, r.out_payload} = moved;
                  if (item.action == ACT_PICK) begin
                     shadow_ent[m] = moved;           // index slot becomes the copy
                  end else begin
                     for (int i = src; i + 1 < m; i++)
                        shadow_ent[i] = shadow_ent[i + 1];
                     shadow_ent[m - 1] = moved;
                     shadow_fill       = m;
                  end
               end
            end
         end
      endcase
      if (shadow_fill > peak_fill)
         peak_fill = shadow_fill;
      r.fill = 9'(shadow_fill);
      return r;
   endfunction

   function automatic req_type make_req(logic [1:0] act, logic [1:0] tag, logic [63:0] pay);
      req_type r;
      r.action        = act;
      r.value_type    = tag;
      r.value_payload = pay;
      return r;
   endfunction

   // non-push action with junk in the ignored value fields
   function automatic req_type bare(logic [1:0] act);
      return make_req(act, 2'($urandom_range(0, 3)), {$urandom, $urandom});
   endfunction

   // small payloads now and then, so a random int on top can act as an index
   function automatic req_type random_push();
      logic [63:0] pay;
      pay = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 8)) : {$urandom, $urandom};
      return make_req(ACT_PUSH, 2'($urandom_range(0, 3)), pay);
   endfunction

   // index for a push-then-pick/roll pair; after the push, shadow_fill
   // entries lie below it, so anything under that is in range
   function automatic logic [63:0] choose_index();
      case ($urandom_range(0, 9))
         0: return {$urandom, $urandom};
         1: return 64'(shadow_fill);
         2: return 64'd0 - 64'($urandom_range(1, 4));
         default: return (shadow_fill == 0) ? 64'd0 : 64'($urandom_range(0, shadow_fill - 1));
      endcase
   endfunction

   function automatic probe_row_type row(logic [1:0] act, logic [1:0] tag, logic [63:0] pay,
                                         bit typed = 1'b0, logic [2:0] st = ST_OK,
                                         int fill = 0, logic [1:0] ot = '0,
                                         logic [63:0] op = '0);
      probe_row_type p;
      p.item             = make_req(act, tag, pay);
      p.typed            = typed;
      p.want.out_type    = ot;
      p.want.out_payload = op;
      p.want.status      = st;
      p.want.fill        = 9'(fill);
      return p;
   endfunction

   // ------------------------------------------------------------------
   // Sender. The expectation is queued as soon as the transaction is
   // offered: valid is never withdrawn, so it is bound to be taken.
   // ------------------------------------------------------------------
   task automatic sender_gap(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic offer(req_type item, bit typed = 1'b0, rsp_type want = '0);
      rsp_type guess;
      guess = apply_action(item);
      rsp_due.push_back(typed ? want : guess);
      act_seen[item.action]++;
      req       <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (!calm && $urandom_range(0, 5) == 0)
         sender_gap($urandom_range(1, 7));
   endtask

   // hold back until every owed response is in
   task automatic drain();
      req_valid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
   endtask

   // Mostly well-formed traffic: pushes, pops and index-push/pick-or-roll
   // pairs; the remainder are bare picks and rolls on whatever is on top.
   task automatic random_phase(int n, int push_w, int pop_w);
      int made;
      int dice;
      made = 0;
      while (made < n) begin
         dice = $urandom_range(0, 99);
         if (dice < push_w) begin
            offer(random_push());
            made++;
         end else if (dice < push_w + pop_w) begin
            offer(bare(ACT_POP));
            made++;
         end else if (dice < 92 && shadow_fill < STACK_DEPTH) begin
            offer(make_req(ACT_PUSH, TAG_INT, choose_index()));
            offer(bare($urandom_range(0, 1) ? ACT_PICK : ACT_ROLL));
            made += 2;
         end else begin
            offer(bare($urandom_range(0, 1) ? ACT_PICK : ACT_ROLL));
            made++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver stall: random bursts, one long hold on request, none once
   // the run has gone calm. Only this process writes rsp_stall.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_taken != hold_asked) begin
         hold_taken = hold_asked;
         hold_left  = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         hold_left = $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Response checker: every accepted transaction against the oldest
   // expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_due.size() == 0) begin
            $error("response with nothing outstanding: %p", rsp);
            mismatches++;
         end else begin
            want = rsp_due.pop_front();
            status_seen[want.status]++;
            if (rsp.out_type !== want.out_type) begin
               $error("out_type: expected %0d, got %0d", want.out_type, rsp.out_type);
               mismatches++;
            end
            if (rsp.out_payload !== want.out_payload) begin
               $error("out_payload: expected %h, got %h", want.out_payload, rsp.out_payload);
               mismatches++;
            end
            if (rsp.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp.status);
               mismatches++;
            end
            if (rsp.fill !== want.fill) begin
               $error("fill: expected %0d, got %0d", want.fill, rsp.fill);
               mismatches++;
            end
         end
      end
   end

   // watchdog: any stretch with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no transaction for %0d cycles, %0d responses owed",
                   idle_cycles, rsp_due.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      probe_row_type plan [$];
      reset     = 1'b1;
      req_valid = 1'b0;
      req       = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-stack errors, index range edges, non-int index,
      // type tags and payload extremes. Typed rows are the obvious ones.
      plan.push_back(row(ACT_POP,  TAG_PTR,   ALL_ONES,      1, ST_UNDER,  0));
      plan.push_back(row(ACT_PICK, TAG_INT,   64'd0,         1, ST_UNDER,  0));
      plan.push_back(row(ACT_ROLL, TAG_BOOL,  64'd0,         1, ST_UNDER,  0));
      plan.push_back(row(ACT_PUSH, TAG_INT,   ALL_ONES,      1, ST_OK,     1));
      plan.push_back(row(ACT_ROLL, TAG_INT,   64'd0,         1, ST_RANGE,  1));  // nothing under index
      plan.push_back(row(ACT_PICK, TAG_INT,   64'd0,         1, ST_RANGE,  1));
      plan.push_back(row(ACT_POP,  TAG_INT,   64'd0,         1, ST_OK,     0, TAG_INT, ALL_ONES));
      plan.push_back(row(ACT_PUSH, TAG_PTR,   ALL_ONES,      1, ST_OK,     1));
      plan.push_back(row(ACT_PUSH, TAG_FLOAT, SIGN_ONLY,     1, ST_OK,     2));
      plan.push_back(row(ACT_PUSH, TAG_BOOL,  64'd1,         1, ST_OK,     3));
      plan.push_back(row(ACT_ROLL, TAG_INT,   64'd0,         1, ST_NOTINT, 3));  // bool on top
      plan.push_back(row(ACT_POP,  TAG_INT,   64'd0,         1, ST_OK,     2, TAG_BOOL, 64'd1));
      plan.push_back(row(ACT_PUSH, TAG_INT,   64'd0,         1, ST_OK,     3));
      plan.push_back(row(ACT_PICK, TAG_PTR,   ALL_ONES));                        // copy top
      plan.push_back(row(ACT_PUSH, TAG_INT,   64'd2,         1, ST_OK,     4));
      plan.push_back(row(ACT_ROLL, TAG_FLOAT, ALL_ONES));                        // deepest
      plan.push_back(row(ACT_PUSH, TAG_INT,   64'd3,         1, ST_OK,     4));
      plan.push_back(row(ACT_ROLL, TAG_INT,   64'd0,         1, ST_RANGE,  4));  // one past bottom
      plan.push_back(row(ACT_PUSH, TAG_INT,   SIGN_ONLY,     1, ST_OK,     5));
      plan.push_back(row(ACT_PICK, TAG_INT,   64'd0,         1, ST_RANGE,  5));  // most negative
      plan.push_back(row(ACT_PUSH, TAG_INT,   MOST_POSITIVE, 1, ST_OK,     6));
      plan.push_back(row(ACT_ROLL, TAG_INT,   64'd0,         1, ST_RANGE,  6));
      plan.push_back(row(ACT_PUSH, TAG_INT,   64'd4,         1, ST_OK,     7));
      plan.push_back(row(ACT_ROLL, TAG_BOOL,  64'd0));
      plan.push_back(row(ACT_PUSH, TAG_INT,   64'd0,         1, ST_OK,     7));
      plan.push_back(row(ACT_ROLL, TAG_INT,   64'd0));                           // roll in place
      foreach (plan[i])
         offer(plan[i].item, plan[i].typed, plan[i].want);
      drain();

      // Balanced traffic; the receiver holds off at the start so the
      // command queue backs up and req_stall rises.
      hold_asked++;
      random_phase(100, 40, 15);

      // Climb to full, then work the deepest pick and roll and overflow.
      while (shadow_fill < STACK_DEPTH - 1)
         offer(random_push());
      offer(make_req(ACT_PUSH, TAG_INT, 64'(STACK_DEPTH - 2)));
      offer(bare(ACT_PICK));                  // copies the bottom entry, stays full
      offer(random_push());                   // overflow
      offer(random_push());
      offer(bare(ACT_POP));
      offer(make_req(ACT_PUSH, TAG_INT, 64'(STACK_DEPTH - 2)));
      offer(bare(ACT_ROLL));                  // bottom entry rolled to the top
      offer(make_req(ACT_PUSH, TAG_INT, 64'(STACK_DEPTH - 1)));
      offer(bare(ACT_ROLL));                  // just out of range
      drain();

      // Mostly pops, back down towards empty.
      random_phase(150, 10, 70);

      // Final stretch at full rate on both sides.
      calm = 1'b1;
      random_phase(80, 40, 15);
      req_valid <= 1'b0;

      while (rsp_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d push, %0d pop, %0d pick, %0d roll; stack peaked at %0d entries.",
               act_seen[ACT_PUSH], act_seen[ACT_POP], act_seen[ACT_PICK], act_seen[ACT_ROLL],
               peak_fill);
      $display("Checked status ok %0d, underflow %0d, overflow %0d, not-int %0d, range %0d.",
               status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_OVER],
               status_seen[ST_NOTINT], status_seen[ST_RANGE]);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
